// ----- sv/order_book_side_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Order book side assertion macros
// Concurrent assertion helpers for the order book side unit.
// ----------------------------------------------------------------------------
`ifndef ORDER_BOOK_SIDE_UNIT_ASSERT_SVH
`define ORDER_BOOK_SIDE_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define OBS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define OBS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define OBS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define OBS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- sv/obs_pkg.sv -----
// ----------------------------------------------------------------------------
// Order book side package
// Request, response, slot, token and command types, request and status codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package obs_pkg;
   localparam logic [2:0] REQ_ADD    = 3'd0;
   localparam logic [2:0] REQ_CANCEL = 3'd1;
   localparam logic [2:0] REQ_FILL   = 3'd2;
   localparam logic [2:0] REQ_BEST   = 3'd3;
   localparam logic [2:0] REQ_VOLUME = 3'd4;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND = 3'd1;
   localparam logic [2:0] ST_WRONG     = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_EMPTY     = 3'd4;
   localparam logic [2:0] ST_DUP       = 3'd5;

   localparam logic [30:0] VOL_MAX = 31'h7FFF_FFFF;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [31:0] ord_id;
      logic        order_side;
      logic [31:0] price;
      logic [23:0] quantity;
   } req_type_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] best_order_id;
      logic [31:0] top_price;
      logic [23:0] best_remaining;
      logic [30:0] volume;
   } rsp_type_type;

   // one resting order
   typedef struct packed {
      logic        valid;
      logic [31:0] id;
      logic [31:0] price;
      logic [23:0] remaining;
   } entry_type;

   // scan token passed cell to cell
   typedef struct packed {
      logic        found;
      logic        gone;
      logic        best_ok;
      logic [31:0] best_id;
      logic [31:0] top_price;
      logic [23:0] best_rem;
      logic [30:0] volume;
   } token_type;

   // broadcast command to all cells
   typedef struct packed {
      logic        add;
      logic [2:0]  op;
      logic [31:0] id;
      logic [31:0] price;
      logic [23:0] quantity;
      logic        side;
   } cmd_type;
endpackage

// ----- sv/order_book_side_unit.sv -----
// ----------------------------------------------------------------------------
// Order book side unit
// One side of a limit order book, price-time priority, in a chain of cells.
// ----------------------------------------------------------------------------
// A request is taken only while the unit is idle. Its scan token then steps
// through the ENTRIES cells, oldest first, one cell per cycle, removing and
// shifting slots as it passes; an add is written at the tail once the scan
// is done, and the response is registered then. The unit takes no new
// request until the one in progress is finished. A stalled response holds
// off both new requests and the completion of a request in progress.
`timescale 1ns / 1ps
`include "order_book_side_unit_assert.svh"
module order_book_side_unit #(
   parameter int ENTRIES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  obs_pkg::req_type_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output obs_pkg::rsp_type_type rsp_data,
   input  logic                  csr_write,
   input  logic                  csr_data
);
   localparam int CW = $clog2(ENTRIES + 1);

   logic                  side_ff;
   logic                  busy_ff;
   logic [CW-1:0]         pos_ff;
   obs_pkg::req_type_type req_ff;
   logic [CW-1:0]         count_ff;
   logic                  rsp_valid_ff;
   obs_pkg::rsp_type_type rsp_ff;

   obs_pkg::cmd_type   cmd;
   obs_pkg::token_type tok [ENTRIES+1];
   obs_pkg::entry_type ent [ENTRIES+1];
   obs_pkg::token_type tend;
   obs_pkg::rsp_type_type res;
   logic full, dup, done, finish, add_ok, shrink;

   assign req_stall = busy_ff || (rsp_valid_ff && rsp_stall);
   assign done      = busy_ff && pos_ff == CW'(ENTRIES);
   assign finish    = done && !(rsp_valid_ff && rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign tok[0]       = '0;
   assign ent[ENTRIES] = '0;
   assign tend         = tok[ENTRIES];
   assign full         = count_ff == CW'(ENTRIES);
   assign dup          = tend.found;
   assign shrink       = tend.gone;

   always_comb begin
      add_ok = req_ff.req_type == obs_pkg::REQ_ADD && req_ff.order_side == side_ff
               && !dup && !full && req_ff.quantity != 24'd0;
      cmd.add      = finish && add_ok;
      cmd.op       = req_ff.req_type;
      cmd.id       = req_ff.ord_id;
      cmd.price    = req_ff.price;
      cmd.quantity = req_ff.quantity;
      cmd.side     = side_ff;
   end

   genvar g;
   generate
      for (g = 0; g < ENTRIES; g++) begin : g_cell
         obs_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .cmd     (cmd),
            .step    (busy_ff && pos_ff == CW'(g)),
            .is_tail (count_ff == CW'(g)),
            .upper   (ent[g+1]),
            .tok_in  (tok[g]),
            .tok_out (tok[g+1]),
            .cur     (ent[g])
         );
      end
   endgenerate

   always_comb begin
      res = '0;
      unique case (req_ff.req_type)
         obs_pkg::REQ_ADD: begin
            if (req_ff.order_side != side_ff) res.status = obs_pkg::ST_WRONG;
            else if (dup)                     res.status = obs_pkg::ST_DUP;
            else if (full)                    res.status = obs_pkg::ST_FULL;
         end
         obs_pkg::REQ_CANCEL, obs_pkg::REQ_FILL: begin
            if (!tend.found) res.status = obs_pkg::ST_NOT_FOUND;
         end
         obs_pkg::REQ_BEST: begin
            if (!tend.best_ok) res.status = obs_pkg::ST_EMPTY;
            else begin
               res.best_order_id  = tend.best_id;
               res.top_price      = tend.top_price;
               res.best_remaining = tend.best_rem;
            end
         end
         obs_pkg::REQ_VOLUME: res.volume = tend.volume;
         default: res = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff      <= 1'b0;
         busy_ff      <= 1'b0;
         pos_ff       <= '0;
         req_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) side_ff <= csr_data;
         rsp_valid_ff <= finish || (rsp_valid_ff && rsp_stall);
         if (req_valid && !req_stall) begin
            busy_ff <= 1'b1;
            pos_ff  <= '0;
            req_ff  <= req_data;
         end
         if (busy_ff && !done) pos_ff <= pos_ff + CW'(1);
         if (finish) begin
            busy_ff <= 1'b0;
            if (add_ok)      count_ff <= count_ff + CW'(1);
            else if (shrink) count_ff <= count_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (finish) rsp_ff <= res;
   end

   `OBS_ASSERT_IMPL(a_no_double, clock, reset, busy_ff, req_stall)
   `OBS_ASSERT_NEXT(a_rsp_after, clock, reset, finish, rsp_valid)
   `OBS_ASSERT_IMPL(a_count_rng, clock, reset, 1'b1, count_ff <= CW'(ENTRIES))
   `OBS_ASSERT_IMPL(a_full_add, clock, reset, full, !add_ok)
endmodule

// ----- sv/obs_cell.sv -----
// ----------------------------------------------------------------------------
// Order book side cell
// Holds one slot; updates the scan token it hands on and shifts down on removal.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module obs_cell (
   input  logic                clock,
   input  logic                reset,
   input  obs_pkg::cmd_type    cmd,
   input  logic                step,
   input  logic                is_tail,
   input  obs_pkg::entry_type  upper,
   input  obs_pkg::token_type  tok_in,
   output obs_pkg::token_type  tok_out,
   output obs_pkg::entry_type  cur
);
   obs_pkg::entry_type ent_ff, ent_in;
   obs_pkg::token_type scan_ff, scan_in;
   logic        hit;
   logic        kill;
   logic        better;
   logic [31:0] vsum;

   assign cur     = ent_ff;
   assign tok_out = scan_ff;
   assign hit     = ent_ff.valid && ent_ff.id == cmd.id;
   assign kill    = hit && (cmd.op == obs_pkg::REQ_CANCEL ||
                    (cmd.op == obs_pkg::REQ_FILL && cmd.quantity >= ent_ff.remaining));

   always_comb begin
      better = cmd.side ? (ent_ff.price < tok_in.top_price)
                        : (ent_ff.price > tok_in.top_price);
      vsum = {1'b0, tok_in.volume} + {8'd0, ent_ff.remaining};
      scan_in = tok_in;
      if (hit) scan_in.found = 1'b1;
      // gone marks that a removed slot lies below this cell
      if (kill) scan_in.gone = 1'b1;
      if (ent_ff.valid && (!tok_in.best_ok || better)) begin
         scan_in.best_ok   = 1'b1;
         scan_in.best_id   = ent_ff.id;
         scan_in.top_price = ent_ff.price;
         scan_in.best_rem  = ent_ff.remaining;
      end
      if (ent_ff.valid && ent_ff.price == cmd.price)
         scan_in.volume = vsum[31] ? obs_pkg::VOL_MAX : vsum[30:0];
   end

   always_comb begin
      ent_in = ent_ff;
      if (cmd.add && is_tail) begin
         ent_in.valid     = 1'b1;
         ent_in.id        = cmd.id;
         ent_in.price     = cmd.price;
         ent_in.remaining = cmd.quantity;
      end else if (step && (tok_in.gone || kill)) begin
         ent_in = upper;
      end else if (step && hit && cmd.op == obs_pkg::REQ_FILL) begin
         ent_in.remaining = ent_ff.remaining - cmd.quantity;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) ent_ff.valid <= 1'b0;
      else       ent_ff.valid <= ent_in.valid;
      ent_ff.id        <= ent_in.id;
      ent_ff.price     <= ent_in.price;
      ent_ff.remaining <= ent_in.remaining;
      if (step) scan_ff <= scan_in;
   end
endmodule

// ----- tb/order_book_checker.sv -----
// ----------------------------------------------------------------------------
// Order book side checker
// Watches request and response channels, tracks the resting-order table in
// price-time order, predicts each response and compares field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module order_book_checker #(
   parameter int ENTRIES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  obs_pkg::req_type_type req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  obs_pkg::rsp_type_type rsp_data,
   input  logic                  csr_write,
   input  logic                  csr_data,
   output int                    fail_count,
   output int                    pending_count
);
   logic                  side_reg;
   logic [31:0]           tbl_id [ENTRIES];
   logic [31:0]           tbl_price [ENTRIES];
   logic [23:0]           tbl_rem [ENTRIES];
   int                    tbl_count;
   obs_pkg::rsp_type_type expected_rsp [$];

   function automatic int find_order(logic [31:0] id);
      for (int i = 0; i < tbl_count; i++)
         if (tbl_id[i] == id) return i;
      return -1;
   endfunction

   function automatic void drop_order(int k);
      for (int i = k; i + 1 < tbl_count; i++) begin
         tbl_id[i] = tbl_id[i + 1];
         tbl_price[i] = tbl_price[i + 1];
         tbl_rem[i] = tbl_rem[i + 1];
      end
      tbl_count--;
   endfunction

   function automatic obs_pkg::rsp_type_type book_response(obs_pkg::req_type_type r);
      obs_pkg::rsp_type_type o;
      int k;
      int b;
      logic [31:0] sum;
      o = '0;
      case (r.req_type)
         obs_pkg::REQ_ADD: begin
            if (r.order_side != side_reg) o.status = obs_pkg::ST_WRONG;
            else if (find_order(r.ord_id) >= 0) o.status = obs_pkg::ST_DUP;
            else if (tbl_count >= ENTRIES) o.status = obs_pkg::ST_FULL;
            else if (r.quantity != 24'd0) begin
               tbl_id[tbl_count] = r.ord_id;
               tbl_price[tbl_count] = r.price;
               tbl_rem[tbl_count] = r.quantity;
               tbl_count++;
            end
         end
         obs_pkg::REQ_CANCEL: begin
            k = find_order(r.ord_id);
            if (k < 0) o.status = obs_pkg::ST_NOT_FOUND;
            else drop_order(k);
         end
         obs_pkg::REQ_FILL: begin
            k = find_order(r.ord_id);
            if (k < 0) o.status = obs_pkg::ST_NOT_FOUND;
            else if (r.quantity >= tbl_rem[k]) drop_order(k);
            else tbl_rem[k] = tbl_rem[k] - r.quantity;
         end
         obs_pkg::REQ_BEST: begin
            if (tbl_count == 0) o.status = obs_pkg::ST_EMPTY;
            else begin
               b = 0;
               for (int i = 1; i < tbl_count; i++)
                  if (side_reg ? (tbl_price[i] < tbl_price[b])
                               : (tbl_price[i] > tbl_price[b])) b = i;
               o.best_order_id = tbl_id[b];
               o.top_price = tbl_price[b];
               o.best_remaining = tbl_rem[b];
            end
         end
         obs_pkg::REQ_VOLUME: begin
            sum = '0;
            for (int i = 0; i < tbl_count; i++)
               if (tbl_price[i] == r.price) begin
                  sum = sum + {8'd0, tbl_rem[i]};
                  if (sum > {1'b0, obs_pkg::VOL_MAX}) sum = {1'b0, obs_pkg::VOL_MAX};
               end
            o.volume = sum[30:0];
         end
         default: ;
      endcase
      return o;
   endfunction

   always @(posedge clock) begin
      obs_pkg::rsp_type_type e;
      if (reset) begin
         side_reg = 1'b0;
         tbl_count = 0;
         expected_rsp.delete();
         fail_count <= 0;
      end else begin
         if (csr_write) side_reg = csr_data;
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               $error("unexpected response %p", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               e = expected_rsp.pop_front();
               if (e != rsp_data) begin
                  fail_count <= fail_count + 1;
                  if (e.status != rsp_data.status)
                     $error("status exp %0d got %0d", e.status, rsp_data.status);
                  if (e.best_order_id != rsp_data.best_order_id)
                     $error("best_order_id exp %0h got %0h", e.best_order_id,
                            rsp_data.best_order_id);
                  if (e.top_price != rsp_data.top_price)
                     $error("top_price exp %0h got %0h", e.top_price,
                            rsp_data.top_price);
                  if (e.best_remaining != rsp_data.best_remaining)
                     $error("best_remaining exp %0h got %0h", e.best_remaining,
                            rsp_data.best_remaining);
                  if (e.volume != rsp_data.volume)
                     $error("volume exp %0h got %0h", e.volume, rsp_data.volume);
               end
            end
         end
         if (req_valid && !req_stall)
            expected_rsp.insert(expected_rsp.size(), book_response(req_data));
      end
      pending_count = expected_rsp.size();
   end

   final begin
      if (expected_rsp.size() != 0) $error("%0d responses missing", expected_rsp.size());
   end
endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// Order book side testbench
// Directed and random add/cancel/fill/query traffic on both book sides,
// with sender gaps and receiver stalls in several phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
   localparam int DEPTH = 64;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   obs_pkg::req_type_type req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   obs_pkg::rsp_type_type rsp_data;
   logic                  csr_write;
   logic                  csr_data;
   int                    fail_count;
   int                    pending_count;
   int                    send_idle_pct;
   int                    stall_pct;
   bit                    hold_rsp;
   int                    idle_cycles;
   logic [31:0]           id_pool [16];
   logic [31:0]           px_pool [4];
   logic                  cur_side;

   order_book_side_unit #(.ENTRIES(DEPTH)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_data(csr_data)
   );

   order_book_checker #(.ENTRIES(DEPTH)) chk (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_data(csr_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(negedge clock) begin
      if (reset || hold_rsp) rsp_stall <= hold_rsp;
      else rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic send_request(obs_pkg::req_type_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_data <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_side(logic s);
      drain();
      csr_data <= s;
      csr_write <= 1'b1;
      @(negedge clock);
      csr_write <= 1'b0;
      cur_side = s;
   endtask

   function automatic obs_pkg::req_type_type make_req(logic [2:0] t, logic [31:0] id,
                                                      logic s, logic [31:0] px,
                                                      logic [23:0] q);
      obs_pkg::req_type_type r;
      r.req_type = t;
      r.ord_id = id;
      r.order_side = s;
      r.price = px;
      r.quantity = q;
      return r;
   endfunction

   function automatic obs_pkg::req_type_type random_req();
      int sel;
      logic [31:0] id;
      logic [31:0] px;
      logic [23:0] q;
      sel = $urandom_range(99);
      id = ($urandom_range(9) == 0) ? $urandom() : id_pool[$urandom_range(15)];
      px = ($urandom_range(7) == 0) ? $urandom() : px_pool[$urandom_range(3)];
      case ($urandom_range(3))
         0: q = '0;
         1: q = 24'($urandom());
         default: q = 24'($urandom_range(50));
      endcase
      if (sel < 40)
         return make_req(obs_pkg::REQ_ADD, id,
                         ($urandom_range(9) == 0) ? ~cur_side : cur_side, px, q);
      if (sel < 52)
         return make_req(obs_pkg::REQ_CANCEL, id, 1'($urandom()), $urandom(),
                         24'($urandom()));
      if (sel < 70)
         return make_req(obs_pkg::REQ_FILL, id, 1'($urandom()), $urandom(), q);
      if (sel < 82)
         return make_req(obs_pkg::REQ_BEST, $urandom(), 1'($urandom()), $urandom(),
                         24'($urandom()));
      if (sel < 96)
         return make_req(obs_pkg::REQ_VOLUME, $urandom(), 1'($urandom()), px,
                         24'($urandom()));
      return make_req(3'($urandom_range(7, 5)), $urandom(), 1'($urandom()), $urandom(),
                      24'($urandom()));
   endfunction

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_write = 1'b0;
      csr_data = 1'b0;
      send_idle_pct = 0;
      stall_pct = 0;
      hold_rsp = 1'b0;
      cur_side = 1'b0;
      foreach (id_pool[i]) id_pool[i] = $urandom();
      id_pool[0] = 32'h0;
      id_pool[1] = 32'hFFFF_FFFF;
      px_pool[0] = 32'h0;
      px_pool[1] = 32'hFFFF_FFFF;
      px_pool[2] = $urandom();
      px_pool[3] = $urandom();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed
      send_request(make_req(obs_pkg::REQ_BEST, '0, 1'b0, '0, '0));
      send_request(make_req(obs_pkg::REQ_ADD, 32'hFFFF_FFFF, 1'b1, 32'd5, 24'd10));
      send_request(make_req(obs_pkg::REQ_ADD, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF,
                            24'hFF_FFFF));
      send_request(make_req(obs_pkg::REQ_ADD, 32'hFFFF_FFFF, 1'b0, 32'd7, 24'd3));
      send_request(make_req(obs_pkg::REQ_ADD, 32'h0, 1'b0, 32'hFFFF_FFFF, 24'hFF_FFFF));
      send_request(make_req(obs_pkg::REQ_ADD, 32'h5, 1'b0, 32'd9, 24'd0));
      send_request(make_req(obs_pkg::REQ_ADD, 32'h6, 1'b0, 32'hFFFF_FFFF, 24'd4));
      send_request(make_req(obs_pkg::REQ_BEST, '0, 1'b0, '0, '0));
      send_request(make_req(obs_pkg::REQ_VOLUME, '0, 1'b0, 32'hFFFF_FFFF, '0));
      send_request(make_req(obs_pkg::REQ_FILL, 32'h6, 1'b0, '0, 24'd0));
      send_request(make_req(obs_pkg::REQ_FILL, 32'h0, 1'b0, '0, 24'hFF_FFFF));
      send_request(make_req(obs_pkg::REQ_FILL, 32'h77, 1'b0, '0, 24'd1));
      send_request(make_req(obs_pkg::REQ_CANCEL, 32'h78, 1'b0, '0, '0));
      send_request(make_req(obs_pkg::REQ_FILL, 32'h6, 1'b0, '0, 24'd1));
      send_request(make_req(obs_pkg::REQ_BEST, '0, 1'b0, '0, '0));
      send_request(make_req(obs_pkg::REQ_CANCEL, 32'hFFFF_FFFF, 1'b0, '0, '0));
      send_request(make_req(3'd5, '1, 1'b1, '1, '1));
      send_request(make_req(3'd7, '0, 1'b0, '0, '0));
      for (int i = 0; i < DEPTH + 2; i++)
         send_request(make_req(obs_pkg::REQ_ADD, 32'h100 + 32'(i), 1'b0, 32'h40,
                               24'hFF_FFFF));
      send_request(make_req(obs_pkg::REQ_VOLUME, '0, 1'b0, 32'h40, '0));
      write_side(1'b1);
      send_request(make_req(obs_pkg::REQ_BEST, '0, 1'b0, '0, '0));
      for (int i = 0; i < DEPTH + 2; i++)
         send_request(make_req(obs_pkg::REQ_CANCEL, 32'h100 + 32'(i), 1'b0, '0, '0));
      send_request(make_req(obs_pkg::REQ_CANCEL, 32'h6, 1'b0, '0, '0));
      send_request(make_req(obs_pkg::REQ_BEST, '0, 1'b0, '0, '0));

      // random phases
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 55; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 55; end
            3: begin send_idle_pct = 18; stall_pct = 18; end
            default: begin send_idle_pct = 0; stall_pct = 0; end
         endcase
         write_side(ph[0]);
         if (ph == 4) begin
            hold_rsp = 1'b1;
            fork
               begin repeat (300) @(negedge clock); hold_rsp = 1'b0; end
               repeat (20) send_request(random_req());
            join
         end
         for (int n = 0; n < 215; n++) begin
            send_request(random_req());
            if ($urandom_range(99) == 0) drain();
         end
      end

      drain();
      repeat (20) @(negedge clock);
      if (fail_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule

// ----- sim.f -----
+incdir+sv
sv/obs_pkg.sv
sv/obs_cell.sv
sv/order_book_side_unit.sv
tb/order_book_checker.sv
tb/tb.sv
